/* rtl/bfh_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the three-hash bloom filter.
// No dependencies.
package bfh_pkg;

    localparam logic [63:0] MOD_START  = 64'd63689;
    localparam logic [63:0] MOD_STEP   = 64'd378551;
    localparam logic [19:0] BITS_RESET = 20'd500000;
    localparam int          WORD_BITS  = 32;

    // one finished string handed from front to back
    typedef struct packed {
        logic [63:0] h1;
        logic [63:0] h2;
        logic [63:0] h3;
        logic        kind;
    } bfh_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } bfh_qstat_t;

endpackage

/* rtl/bfh_front.sv */
`timescale 1ns / 1ps
// Front end: takes string bytes, updates the three running hashes.
// h3 reduction uses a 64-step restoring divider. Depends on bfh_pkg.
module bfh_front
    import bfh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_byte,
    input  logic       char_valid,
    input  logic       last,
    input  logic       kind,
    input  bfh_qstat_t qstat,
    output logic       push,
    output bfh_entry_t push_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] h1_reg, h1_next;
    logic [63:0] h2_reg, h2_next;
    logic [63:0] h3_reg, h3_next;
    logic [63:0] m_reg, m_next;
    logic [63:0] dvd_reg, dvd_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] c_reg, c_next;
    logic        last_reg, last_next;
    logic        kind_reg, kind_next;

    logic        accept;
    logic [63:0] c_in;
    logic [64:0] trial;

    assign in_ready = en && (state_reg == ST_IDLE) && !qstat.full;
    assign accept   = in_valid && in_ready;
    assign c_in     = {{56{char_byte[7]}}, char_byte};
    assign trial    = {rem_reg, dvd_reg[63]};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        h1_next    = h1_reg;
        h2_next    = h2_reg;
        h3_next    = h3_reg;
        m_next     = m_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        c_next     = c_reg;
        last_next  = last_reg;
        kind_next  = kind_reg;
        push       = 1'b0;
        push_data  = '{h1: h1_reg, h2: h2_reg, h3: h3_reg, kind: kind_reg};
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (char_valid)
                    begin
                        h1_next    = (h1_reg << 7) + (h1_reg << 1) + h1_reg + c_in;
                        h2_next    = (h2_reg << 16) - h2_reg + c_in;
                        c_next     = c_in;
                        dvd_next   = h3_reg;
                        rem_next   = '0;
                        acc_next   = '0;
                        cnt_next   = '0;
                        last_next  = last;
                        kind_next  = kind;
                        state_next = ST_DIV;
                    end
                    else if (last)
                    begin
                        push      = 1'b1;
                        push_data = '{h1: h1_reg, h2: h2_reg, h3: h3_reg, kind: kind};
                        h1_next   = '0;
                        h2_next   = '0;
                        h3_next   = '0;
                        m_next    = MOD_START;
                    end
                end
            end
            ST_DIV:
            begin
                if (trial >= {1'b0, m_reg})
                    rem_next = 64'(trial - {1'b0, m_reg});
                else
                    rem_next = trial[63:0];
                dvd_next = {dvd_reg[62:0], 1'b0};
                // modulus times the step constant, one partial product a cycle
                if (MOD_STEP[cnt_reg])
                    acc_next = acc_reg + (m_reg << cnt_reg);
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                h3_next    = ((m_reg == '0) ? h3_reg : rem_reg) + c_reg;
                m_next     = acc_reg;
                state_next = ST_IDLE;
                if (last_reg)
                begin
                    push      = 1'b1;
                    push_data = '{h1: h1_reg, h2: h2_reg, h3: h3_next, kind: kind_reg};
                    h1_next   = '0;
                    h2_next   = '0;
                    h3_next   = '0;
                    m_next    = MOD_START;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            h1_reg    <= '0;
            h2_reg    <= '0;
            h3_reg    <= '0;
            m_reg     <= MOD_START;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            h1_reg    <= h1_next;
            h2_reg    <= h2_next;
            h3_reg    <= h3_next;
            m_reg     <= m_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        acc_reg  <= acc_next;
        c_reg    <= c_next;
        kind_reg <= kind_next;
    end

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full) else $error("push into full queue");
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == 6'd63) |=> state_reg == ST_FIN)
        else $error("divider did not finish");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && m_reg != '0) |-> rem_reg < m_reg)
        else $error("remainder not below modulus");

endmodule

/* rtl/bfh_queue.sv */
`timescale 1ns / 1ps
// Two-entry queue between hash front end and filter back end.
// Depends on bfh_pkg.
module bfh_queue
    import bfh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  bfh_entry_t push_data,
    input  logic       pop,
    output bfh_entry_t pop_data,
    output bfh_qstat_t qstat
);

    bfh_entry_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign pop_data    = mem_reg[rp_reg];
    assign qstat.full  = (cnt_reg == 2'd2);
    assign qstat.empty = (cnt_reg == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_data;
    end

endmodule

/* rtl/bfh_back.sv */
`timescale 1ns / 1ps
// Back end: reduces each hash mod the bits in use, then sets or tests
// the bit in the filter memory. Clears the memory after reset. Depends on bfh_pkg.
module bfh_back
    import bfh_pkg::*;
#(
    parameter int FILTER_BITS = 524288
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [19:0] bits_in_use,
    input  bfh_qstat_t  qstat,
    input  bfh_entry_t  pop_data,
    output logic        pop,
    output logic        clearing,
    output logic        res_valid,
    input  logic        res_ready,
    output logic        maybe_present,
    output logic        was_query
);

    localparam int ROWS = (FILTER_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int NW   = $clog2(FILTER_BITS + 1);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [RW-1:0] clr_reg, clr_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [1:0]    sel_reg, sel_next;
    logic [63:0]   dvd_reg, dvd_next;
    logic [NW-1:0] rem_reg, rem_next;
    bfh_entry_t    ent_reg, ent_next;
    logic          pres_reg, pres_next;

    logic [WORD_BITS-1:0] mem [ROWS];
    logic [WORD_BITS-1:0] rd_reg;
    logic                 mem_we;
    logic [RW-1:0]        mem_addr;
    logic [WORD_BITS-1:0] mem_wdata;

    logic [NW-1:0] n_eff;
    logic [NW:0]   trial;
    logic [63:0]   cur_hash;
    logic [RW-1:0] row;

    always_comb
    begin
        if (bits_in_use == '0)
            n_eff = NW'(1);
        else if (32'(bits_in_use) > 32'(FILTER_BITS))
            n_eff = NW'(FILTER_BITS);
        else
            n_eff = NW'(bits_in_use);
    end

    always_comb
    begin
        case (sel_reg)
            2'd0:    cur_hash = ent_reg.h1;
            2'd1:    cur_hash = ent_reg.h2;
            default: cur_hash = ent_reg.h3;
        endcase
    end

    assign trial         = {rem_reg, dvd_reg[63]};
    assign row           = RW'(rem_reg >> 5);
    assign clearing      = (state_reg == ST_CLR);
    assign res_valid     = (state_reg == ST_OUT);
    assign maybe_present = pres_reg;
    assign was_query     = ent_reg.kind;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        ent_next   = ent_reg;
        pres_next  = pres_reg;
        pop        = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = row;
        mem_wdata  = rd_reg | (WORD_BITS'(1) << rem_reg[4:0]);
        case (state_reg)
            ST_CLR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + RW'(1);
                if (32'(clr_reg) == ROWS - 1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop        = 1'b1;
                    ent_next   = pop_data;
                    sel_next   = '0;
                    dvd_next   = pop_data.h1;
                    rem_next   = '0;
                    cnt_next   = '0;
                    pres_next  = pop_data.kind;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (trial >= {1'b0, n_eff})
                    rem_next = NW'(trial - {1'b0, n_eff});
                else
                    rem_next = trial[NW-1:0];
                dvd_next = {dvd_reg[62:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = ST_RD;
            end
            ST_RD:
                state_next = ST_UPD;
            ST_UPD:
            begin
                if (ent_reg.kind)
                    pres_next = pres_reg & rd_reg[rem_reg[4:0]];
                else
                    mem_we = 1'b1;
                if (sel_reg == 2'd2)
                    state_next = ST_OUT;
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_OUT:
            begin
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
        if (state_reg == ST_UPD && sel_reg != 2'd2)
            dvd_next = (sel_reg == 2'd0) ? ent_reg.h2 : ent_reg.h3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
            sel_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        ent_reg  <= ent_next;
        pres_reg <= pres_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_reg <= mem[mem_addr];
    end

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !res_valid) else $error("result during clear");
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RD |-> rem_reg < n_eff) else $error("index out of range");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE && !qstat.empty)) else $error("bad pop");
    a_insert_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !was_query) |-> !maybe_present) else $error("insert reports present");

    // cur_hash gives a readable view of the hash being reduced
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == '0) |-> dvd_reg == cur_hash)
        else $error("divider loaded wrong hash");

endmodule

/* rtl/bloom_filter_three_string_hashes.sv */
`timescale 1ns / 1ps
// Top level of the three-hash bloom filter: config register, front, queue, back.
// Depends on bfh_pkg, bfh_front, bfh_queue, bfh_back.
//
//  channel  dir  handshake         payload
//  s_*      in   s_tvalid/tready   tdata[7:0] char_byte, [8] char_valid; tuser kind; tlast
//  m_*      out  m_tvalid/tready   tdata[0] maybe_present; tuser was_query
//  cfg_*    in   cfg_valid/ready   cfg_data bits_in_use
//
// A byte with char_valid passes a load, the 64-step divider for h3 and a finish step;
// other beats are taken one per cycle while the front is idle and the queue is not full.
// In the back end each string gets three 64-step reductions by bits_in_use, each with a
// memory read and update. After reset the filter memory is cleared one 32-bit row per cycle
// (FILTER_BITS/32 rows, 16384 by default); no s_* beat is taken until then.
// The queue holds two finished strings so the front keeps hashing while the back works.
module bloom_filter_three_string_hashes
    import bfh_pkg::*;
#(
    parameter int FILTER_BITS = 524288
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] char_byte, [8] char_valid
    input  logic        s_tuser,   // kind
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] maybe_present
    output logic        m_tuser,   // was_query
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [19:0] cfg_data
);

    logic [19:0] bits_reg;
    logic        clearing;
    logic        push, pop;
    bfh_entry_t  push_data, pop_data;
    bfh_qstat_t  qstat;
    logic        maybe_present;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bits_reg <= BITS_RESET;
        else if (cfg_valid)
            bits_reg <= cfg_data;
    end

    bfh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (!clearing),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .char_byte  (s_tdata[7:0]),
        .char_valid (s_tdata[8]),
        .last       (s_tlast),
        .kind       (s_tuser),
        .qstat      (qstat),
        .push       (push),
        .push_data  (push_data)
    );

    bfh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    bfh_back #(
        .FILTER_BITS (FILTER_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .bits_in_use   (bits_reg),
        .qstat         (qstat),
        .pop_data      (pop_data),
        .pop           (pop),
        .clearing      (clearing),
        .res_valid     (m_tvalid),
        .res_ready     (m_tready),
        .maybe_present (maybe_present),
        .was_query     (m_tuser)
    );

    assign m_tdata = {7'd0, maybe_present};

endmodule
